// ----- rtl/core/crp_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helper functions of the conv / relu / pool layer
// no dependencies
package crp_pkg;

  localparam int MAX_IMAGE_DIM = 32;
  localparam int MAX_KERNEL    = 7;
  localparam int MAX_POOL      = 4;
  localparam int WEIGHT_COUNT  = MAX_KERNEL * MAX_KERNEL;

  localparam int REG_COUNT = 7;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int PADDR_W   = REG_IDX_W + 2;

  localparam int DIM_W   = 6;
  localparam int POS_W   = 5;
  localparam int KSZ_W   = 3;
  localparam int POOL_W  = 3;
  localparam int WIDX_W  = 6;
  localparam int SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int PHASE_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int COL_IDX_W = $clog2(MAX_IMAGE_DIM);

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ROW_W    = PROD_W + $clog2(MAX_KERNEL) + 1;
  localparam int ACC_W    = ROW_W + $clog2(MAX_KERNEL) + 2;
  localparam int PSUM_W   = SAMPLE_W + 2 * $clog2(MAX_POOL);
  localparam int RECIP_W  = 18;
  localparam int MEAN_W   = PSUM_W + RECIP_W;
  localparam int DIVX_W   = DIM_W + 10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_SIZE  = 3'd2,
    REG_POOL_SIZE    = 3'd3,
    REG_POOL_METHOD  = 3'd4,
    REG_KERNEL_BIAS  = 3'd5,
    REG_RELU_ENABLE  = 3'd6
  } reg_idx_e;

  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_e;

  typedef enum logic {
    METHOD_MAX = 1'b0,
    METHOD_AVG = 1'b1
  } pool_method_e;

  typedef struct packed {
    logic             first;
    logic             is_end;
    logic [POS_W-1:0] pr;
    logic [POS_W-1:0] pc;
    logic             last;
  } pool_tag_t;

  typedef struct packed {
    cmd_e                       cmd;
    logic [WIDX_W-1:0]          widx;
    logic signed [SAMPLE_W-1:0] value;
    logic [SLOT_W-1:0]          slot;
    logic                       active;
    pool_tag_t                  tag;
  } pix_item_t;

  typedef struct packed {
    logic [KSZ_W-1:0]           ksize;
    logic signed [SAMPLE_W-1:0] bias;
    logic                       relu_en;
  } conv_cfg_t;

  typedef struct packed {
    logic [POOL_W-1:0] psize;
    pool_method_e      method;
  } pool_cfg_t;

  // quotient of a small value by the pool side, reciprocal multiply
  function automatic logic [DIM_W-1:0] div_pool(input logic [DIM_W-1:0] x,
                                                input logic [POOL_W-1:0] p);
    logic [DIVX_W-1:0] xe;
    logic [DIVX_W-1:0] q;
    xe = DIVX_W'(x);
    case (p)
      POOL_W'(2): q = xe >> 1;
      POOL_W'(3): q = (xe * DIVX_W'(342)) >> 10;
      POOL_W'(4): q = xe >> 2;
      POOL_W'(5): q = (xe * DIVX_W'(205)) >> 10;
      POOL_W'(6): q = (xe * DIVX_W'(171)) >> 10;
      POOL_W'(7): q = (xe * DIVX_W'(147)) >> 10;
      default:    q = xe;
    endcase
    return DIM_W'(q);
  endfunction

  // unsigned q2.16 reciprocal of the window area
  function automatic logic [RECIP_W-1:0] recip_q16(input logic [POOL_W-1:0] p);
    logic [RECIP_W-1:0] r;
    case (p)
      POOL_W'(2): r = RECIP_W'(16384);
      POOL_W'(3): r = RECIP_W'(7282);
      POOL_W'(4): r = RECIP_W'(4096);
      POOL_W'(5): r = RECIP_W'(2621);
      POOL_W'(6): r = RECIP_W'(1820);
      POOL_W'(7): r = RECIP_W'(1337);
      default:    r = RECIP_W'(65536);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/crp_linebuf.sv -----
`timescale 1ns / 1ps
// line buffer: one bank per kept image row, all banks read at one column
// depends on crp_pkg
module crp_linebuf import crp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [SLOT_W-1:0]          wr_slot_i,
  input  logic [COL_IDX_W-1:0]       wr_col_i,
  input  logic signed [SAMPLE_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [COL_IDX_W-1:0]       rd_col_i,
  output logic signed [SAMPLE_W-1:0] rd_data_o [MAX_KERNEL]
);

  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    logic signed [SAMPLE_W-1:0] mem [MAX_IMAGE_DIM];
    logic signed [SAMPLE_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_slot_i == SLOT_W'(b))) begin
        mem[wr_col_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem[rd_col_i];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

// ----- rtl/core/crp_conv.sv -----
`timescale 1ns / 1ps
// window register, kernel weights, 49-lane multiplier array, adder tree,
// bias, relu and rounding; depends on crp_pkg
module crp_conv import crp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  conv_cfg_t                  cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pix_item_t                  in_item_i,
  input  logic signed [SAMPLE_W-1:0] lb_data_i [MAX_KERNEL],
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pool_tag_t                  out_tag_o,
  output logic signed [SAMPLE_W-1:0] out_act_o
);

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic r1, r2, r3, r4, r5, r6;

  pix_item_t s1_q;
  pool_tag_t s2_tag_q, s3_tag_q, s4_tag_q, s5_tag_q, s6_tag_q;

  logic signed [SAMPLE_W-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [SAMPLE_W-1:0] wt_q [WEIGHT_COUNT];
  logic signed [SAMPLE_W-1:0] colv [MAX_KERNEL];
  logic signed [SAMPLE_W-1:0] lane_w [MAX_KERNEL][MAX_KERNEL];
  logic                       lane_on [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0]   prod_d [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0]   s3_prod_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [ROW_W-1:0]    row_d [MAX_KERNEL];
  logic signed [ROW_W-1:0]    s4_row_q [MAX_KERNEL];
  logic signed [ACC_W-1:0]    acc_d, s5_acc_q;
  logic signed [ACC_W-1:0]    relu_v, rnd_v;
  logic signed [SAMPLE_W-1:0] act_d, s6_act_q;

  logic s1_go, shift_en, wt_wr;

  assign r6 = !s6_v_q || out_ready_i;
  assign r5 = !s5_v_q || r6;
  assign r4 = !s4_v_q || r5;
  assign r3 = !s3_v_q || r4;
  assign r2 = !s2_v_q || r3;
  assign r1 = !s1_v_q || r2;

  assign in_ready_o = r1;
  assign s1_go      = s1_v_q && r2;
  assign shift_en   = s1_go && (s1_q.cmd == CMD_PIXEL);
  assign wt_wr      = s1_go && (s1_q.cmd == CMD_WEIGHT) && (s1_q.widx < WIDX_W'(WEIGHT_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (r1) s1_v_q <= in_valid_i;
      if (r2) s2_v_q <= shift_en && s1_q.active;
      if (r3) s3_v_q <= s2_v_q;
      if (r4) s4_v_q <= s3_v_q;
      if (r5) s5_v_q <= s4_v_q;
      if (r6) s6_v_q <= s5_v_q;
    end
  end

  // column entering the window: oldest kept row first, new sample last
  always_comb begin
    logic [SLOT_W:0] s;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      s = {1'b0, s1_q.slot} + (SLOT_W+1)'(j + 1);
      if (s >= (SLOT_W+1)'(MAX_KERNEL)) s = s - (SLOT_W+1)'(MAX_KERNEL);
      colv[j] = (j == MAX_KERNEL - 1) ? s1_q.value : lb_data_i[s[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) s1_q <= in_item_i;
    if (shift_en) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        for (int i = 0; i < MAX_KERNEL - 1; i++) begin
          win_q[j][i] <= win_q[j][i+1];
        end
        win_q[j][MAX_KERNEL-1] <= colv[j];
      end
    end
    if (wt_wr) wt_q[s1_q.widx] <= s1_q.value;
    if (r2) s2_tag_q <= s1_q.tag;
  end

  // lane (j,i) meets the bottom-right kernel-sized corner of the window
  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        lane_on[j][i] = 1'b0;
        lane_w[j][i]  = '0;
        for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
          if ((cfg_i.ksize == KSZ_W'(kk)) && (j >= MAX_KERNEL - kk) &&
              (i >= MAX_KERNEL - kk)) begin
            lane_on[j][i] = 1'b1;
            lane_w[j][i]  = wt_q[(j - MAX_KERNEL + kk) * kk + (i - MAX_KERNEL + kk)];
          end
        end
        if (lane_on[j][i]) begin
          prod_d[j][i] = lane_w[j][i] * win_q[j][i];
        end else begin
          prod_d[j][i] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      row_d[j] = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        row_d[j] = row_d[j] + ROW_W'(s3_prod_q[j][i]);
      end
    end
  end

  always_comb begin
    acc_d = ACC_W'(cfg_i.bias) <<< 14;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      acc_d = acc_d + ACC_W'(s4_row_q[j]);
    end
  end

  always_comb begin
    relu_v = (cfg_i.relu_en && (s5_acc_q < 0)) ? '0 : s5_acc_q;
    rnd_v  = (relu_v + ACC_W'(8192)) >>> 14;
    if (rnd_v > ACC_W'(32767)) begin
      act_d = SAMPLE_W'(32767);
    end else if (rnd_v < ACC_W'(-32768)) begin
      act_d = SAMPLE_W'(-32768);
    end else begin
      act_d = rnd_v[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3) begin
      s3_prod_q <= prod_d;
      s3_tag_q  <= s2_tag_q;
    end
    if (r4) begin
      s4_row_q <= row_d;
      s4_tag_q <= s3_tag_q;
    end
    if (r5) begin
      s5_acc_q <= acc_d;
      s5_tag_q <= s4_tag_q;
    end
    if (r6) begin
      s6_act_q <= act_d;
      s6_tag_q <= s5_tag_q;
    end
  end

  assign out_valid_o = s6_v_q;
  assign out_tag_o   = s6_tag_q;
  assign out_act_o   = s6_act_q;

endmodule

// ----- rtl/core/crp_pool.sv -----
`timescale 1ns / 1ps
// pooling: per-column running max or sum, mean scaling and output register
// depends on crp_pkg
module crp_pool import crp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pool_cfg_t                  cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pool_tag_t                  in_tag_i,
  input  logic signed [SAMPLE_W-1:0] in_act_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] pooled_value_o,
  output logic [POS_W-1:0]           pool_row_o,
  output logic [POS_W-1:0]           pool_col_o,
  output logic                       last_o
);

  logic signed [PSUM_W-1:0] part_q [MAX_IMAGE_DIM];
  logic signed [PSUM_W-1:0] cur, act_x, part_d;

  logic s7_v_q, s8_v_q, out_v_q;
  logic r7, r8, ro, in_go;

  logic signed [PSUM_W-1:0]   s7_sum_q;
  pool_tag_t                  s7_tag_q, s8_tag_q;
  logic signed [PSUM_W-1:0]   s8_sum_q;
  logic signed [MEAN_W-1:0]   prod_d, s8_prod_q, rnd_v;
  logic signed [SAMPLE_W-1:0] res_d;
  logic signed [SAMPLE_W-1:0] out_val_q;
  pool_tag_t                  out_tag_q;

  assign ro = !out_v_q || out_ready_i;
  assign r8 = !s8_v_q || ro;
  assign r7 = !s7_v_q || r8;

  assign in_ready_o = r7;
  assign in_go      = in_valid_i && r7;

  always_comb begin
    cur   = part_q[in_tag_i.pc[COL_IDX_W-1:0]];
    act_x = PSUM_W'(in_act_i);
    if (in_tag_i.first) begin
      part_d = act_x;
    end else if (cfg_i.method == METHOD_MAX) begin
      part_d = (act_x > cur) ? act_x : cur;
    end else begin
      part_d = cur + act_x;
    end
  end

  assign prod_d = MEAN_W'(s7_sum_q) * MEAN_W'($signed(recip_q16(cfg_i.psize)));

  always_comb begin
    rnd_v = (s8_prod_q + MEAN_W'(32768)) >>> 16;
    if (cfg_i.method == METHOD_MAX) begin
      res_d = s8_sum_q[SAMPLE_W-1:0];
    end else if (rnd_v > MEAN_W'(32767)) begin
      res_d = SAMPLE_W'(32767);
    end else if (rnd_v < MEAN_W'(-32768)) begin
      res_d = SAMPLE_W'(-32768);
    end else begin
      res_d = rnd_v[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r7) s7_v_q <= in_valid_i && in_tag_i.is_end;
      if (r8) s8_v_q <= s7_v_q;
      if (ro) out_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) part_q[in_tag_i.pc[COL_IDX_W-1:0]] <= part_d;
    if (r7) begin
      s7_sum_q <= part_d;
      s7_tag_q <= in_tag_i;
    end
    if (r8) begin
      s8_prod_q <= prod_d;
      s8_sum_q  <= s7_sum_q;
      s8_tag_q  <= s7_tag_q;
    end
    if (ro) begin
      out_val_q <= res_d;
      out_tag_q <= s8_tag_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign pooled_value_o = out_val_q;
  assign pool_row_o     = out_tag_q.pr;
  assign pool_col_o     = out_tag_q.pc;
  assign last_o         = out_tag_q.last;

endmodule

// ----- rtl/core/conv_relu_pool_layer_core.sv -----
`timescale 1ns / 1ps
// top level of the conv / relu / pool layer: register port, raster counters
// depends on crp_pkg, crp_linebuf, crp_conv, crp_pool

// One request is taken per clock cycle while the pipeline is not stalled, weight loads
// and pixels alike. A pooled result passes the conv stages s1 to s6, the pool stages
// s7 and s8 and the output register before it is presented.
// The rate is set by the 49-lane multiplier array, which sees a full kernel
// window every cycle: the line buffer banks deliver one column of the kept
// rows per pixel and the window register shifts by one column. Downstream
// back-pressure stalls the pipeline one stage at a time, so requests keep
// flowing into empty stages while a result waits at the output.
module conv_relu_pool_layer_core import crp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [WIDX_W-1:0]          weight_index_i,
  input  logic signed [SAMPLE_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] pooled_value_o,
  output logic [POS_W-1:0]           pool_row_o,
  output logic [POS_W-1:0]           pool_col_o,
  output logic                       last_o
);

  logic [DIM_W-1:0]           img_w_q, img_h_q;
  logic [KSZ_W-1:0]           ksize_q;
  logic [POOL_W-1:0]          psize_q;
  pool_method_e               method_q;
  logic signed [SAMPLE_W-1:0] bias_q;
  logic                       relu_q;

  logic     cfg_wr, geom_wr;
  reg_idx_e cfg_idx;

  logic [DIM_W-1:0]  w_cl, h_cl, k_ext, cw, ch, qx, qy, rem_x, rem_y;
  logic [DIM_W-1:0]  col_start, row_start;
  logic [KSZ_W-1:0]  k_cl;
  logic [POOL_W-1:0] p_cl;
  logic              conv_ok;

  logic [POS_W-1:0]   col_q, col_d, row_q, row_d, pc_q, pc_d, pr_q, pr_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [PHASE_W-1:0] rx_q, rx_d, ry_q, ry_d;

  logic in_acc, pix_acc, col_end, row_end, col_in, row_in, rx_last, ry_last;

  pix_item_t item;
  conv_cfg_t conv_cfg;
  pool_cfg_t pool_cfg;

  logic signed [SAMPLE_W-1:0] lb_data [MAX_KERNEL];

  logic                       cv_valid, cv_ready;
  pool_tag_t                  cv_tag;
  logic signed [SAMPLE_W-1:0] cv_act;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign geom_wr = cfg_wr && ((cfg_idx == REG_IMAGE_WIDTH) || (cfg_idx == REG_IMAGE_HEIGHT) ||
                              (cfg_idx == REG_KERNEL_SIZE) || (cfg_idx == REG_POOL_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= DIM_W'(32);
      img_h_q  <= DIM_W'(32);
      ksize_q  <= KSZ_W'(7);
      psize_q  <= POOL_W'(2);
      method_q <= METHOD_MAX;
      bias_q   <= '0;
      relu_q   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  img_w_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q  <= pwdata[DIM_W-1:0];
        REG_KERNEL_SIZE:  ksize_q  <= pwdata[KSZ_W-1:0];
        REG_POOL_SIZE:    psize_q  <= pwdata[POOL_W-1:0];
        REG_POOL_METHOD:  method_q <= pool_method_e'(pwdata[0]);
        REG_KERNEL_BIAS:  bias_q   <= pwdata[SAMPLE_W-1:0];
        REG_RELU_ENABLE:  relu_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(img_w_q);
      REG_IMAGE_HEIGHT: prdata = 32'(img_h_q);
      REG_KERNEL_SIZE:  prdata = 32'(ksize_q);
      REG_POOL_SIZE:    prdata = 32'(psize_q);
      REG_POOL_METHOD:  prdata = 32'(method_q);
      REG_KERNEL_BIAS:  prdata = 32'($unsigned(bias_q));
      REG_RELU_ENABLE:  prdata = 32'(relu_q);
      default:          prdata = '0;
    endcase
  end

  // geometry in use
  always_comb begin
    w_cl = (img_w_q == '0) ? DIM_W'(1) :
           (img_w_q > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : img_w_q;
    h_cl = (img_h_q == '0) ? DIM_W'(1) :
           (img_h_q > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : img_h_q;
    k_cl = (ksize_q == '0) ? KSZ_W'(1) :
           (ksize_q > KSZ_W'(MAX_KERNEL)) ? KSZ_W'(MAX_KERNEL) : ksize_q;
    p_cl = (psize_q == '0) ? POOL_W'(1) :
           (psize_q > POOL_W'(MAX_POOL)) ? POOL_W'(MAX_POOL) : psize_q;
    k_ext     = DIM_W'(k_cl);
    conv_ok   = (w_cl >= k_ext) && (h_cl >= k_ext);
    cw        = (w_cl >= k_ext) ? (w_cl - k_ext + DIM_W'(1)) : '0;
    ch        = (h_cl >= k_ext) ? (h_cl - k_ext + DIM_W'(1)) : '0;
    qx        = div_pool(cw, p_cl);
    qy        = div_pool(ch, p_cl);
    rem_x     = cw - qx * DIM_W'(p_cl);
    rem_y     = ch - qy * DIM_W'(p_cl);
    col_start = k_ext - DIM_W'(1) + rem_x;
    row_start = k_ext - DIM_W'(1) + rem_y;
  end

  // raster position and pooling phase of the next pixel
  assign in_acc  = in_valid_i && in_ready_o;
  assign pix_acc = in_acc && (cmd_e'(cmd_i) == CMD_PIXEL);
  assign col_end = (DIM_W'(col_q) == w_cl - DIM_W'(1));
  assign row_end = (DIM_W'(row_q) == h_cl - DIM_W'(1));
  assign col_in  = (DIM_W'(col_q) >= col_start);
  assign row_in  = (DIM_W'(row_q) >= row_start);
  assign rx_last = (POOL_W'(rx_q) == p_cl - POOL_W'(1));
  assign ry_last = (POOL_W'(ry_q) == p_cl - POOL_W'(1));

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    rx_d   = rx_q;
    ry_d   = ry_q;
    pc_d   = pc_q;
    pr_d   = pr_q;
    if (geom_wr) begin
      col_d  = '0;
      row_d  = '0;
      slot_d = '0;
      rx_d   = '0;
      ry_d   = '0;
      pc_d   = '0;
      pr_d   = '0;
    end else if (pix_acc) begin
      if (col_end) begin
        col_d = '0;
        rx_d  = '0;
        pc_d  = '0;
        if (row_end) begin
          row_d  = '0;
          slot_d = '0;
          ry_d   = '0;
          pr_d   = '0;
        end else begin
          row_d  = row_q + POS_W'(1);
          slot_d = (slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_q + SLOT_W'(1);
          if (row_in) begin
            if (ry_last) begin
              ry_d = '0;
              pr_d = pr_q + POS_W'(1);
            end else begin
              ry_d = ry_q + PHASE_W'(1);
            end
          end
        end
      end else begin
        col_d = col_q + POS_W'(1);
        if (col_in) begin
          if (rx_last) begin
            rx_d = '0;
            pc_d = pc_q + POS_W'(1);
          end else begin
            rx_d = rx_q + PHASE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      rx_q   <= '0;
      ry_q   <= '0;
      pc_q   <= '0;
      pr_q   <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      pc_q   <= pc_d;
      pr_q   <= pr_d;
    end
  end

  always_comb begin
    item.cmd        = cmd_e'(cmd_i);
    item.widx       = weight_index_i;
    item.value      = value_i;
    item.slot       = slot_q;
    item.active     = conv_ok && col_in && row_in;
    item.tag.first  = (rx_q == '0) && (ry_q == '0);
    item.tag.is_end = rx_last && ry_last;
    item.tag.pr     = pr_q;
    item.tag.pc     = pc_q;
    item.tag.last   = ((DIM_W'(pr_q) + DIM_W'(1)) == qy) && ((DIM_W'(pc_q) + DIM_W'(1)) == qx);
  end

  assign conv_cfg.ksize   = k_cl;
  assign conv_cfg.bias    = bias_q;
  assign conv_cfg.relu_en = relu_q;
  assign pool_cfg.psize   = p_cl;
  assign pool_cfg.method  = method_q;

  crp_linebuf u_linebuf (
    .clk_i     (clk_i),
    .wr_en_i   (pix_acc),
    .wr_slot_i (slot_q),
    .wr_col_i  (col_q[COL_IDX_W-1:0]),
    .wr_data_i (value_i),
    .rd_en_i   (in_acc),
    .rd_col_i  (col_q[COL_IDX_W-1:0]),
    .rd_data_o (lb_data)
  );

  crp_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (conv_cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (item),
    .lb_data_i   (lb_data),
    .out_valid_o (cv_valid),
    .out_ready_i (cv_ready),
    .out_tag_o   (cv_tag),
    .out_act_o   (cv_act)
  );

  crp_pool u_pool (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (pool_cfg),
    .in_valid_i     (cv_valid),
    .in_ready_o     (cv_ready),
    .in_tag_i       (cv_tag),
    .in_act_i       (cv_act),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pooled_value_o (pooled_value_o),
    .pool_row_o     (pool_row_o),
    .pool_col_o     (pool_col_o),
    .last_o         (last_o)
  );

  // raster position always inside the configured image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DIM_W'(col_q) < w_cl) && (DIM_W'(row_q) < h_cl))
    else $error("raster position outside image");

  // row slot and pooling phases stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q < SLOT_W'(MAX_KERNEL)) && (POOL_W'(rx_q) < p_cl) && (POOL_W'(ry_q) < p_cl))
    else $error("slot or pooling phase out of range");

  // a pixel that does not end its row moves the column on by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && !col_end && !geom_wr) |=> (col_q == $past(col_q) + POS_W'(1)))
    else $error("column counter did not advance");

endmodule

// ----- tb/conv_relu_pool_layer_core_check.sv -----
`timescale 1ns / 1ps
// checker of the conv / relu / pool layer: follows register writes and requests,
// predicts pooled results and compares them; depends on crp_pkg
module conv_relu_pool_layer_core_check import crp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [WIDX_W-1:0]          weight_index_i,
  input  logic signed [SAMPLE_W-1:0] value_i,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic signed [SAMPLE_W-1:0] pooled_value_o,
  input  logic [POS_W-1:0]           pool_row_o,
  input  logic [POS_W-1:0]           pool_col_o,
  input  logic                       last_o,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic                       last;
  } pooled_t;

  localparam longint AREA_RECIP [0:4] = '{65536, 65536, 16384, 7282, 4096};

  pooled_t                    pooled_expected[$];
  logic [5:0]                 width_q, height_q;
  logic [2:0]                 ksize_q, psize_q;
  pool_method_e               method_q;
  logic signed [SAMPLE_W-1:0] bias_q;
  logic                       relu_q;
  logic signed [SAMPLE_W-1:0] weights[WEIGHT_COUNT];
  logic signed [SAMPLE_W-1:0] rows_kept[MAX_KERNEL][MAX_IMAGE_DIM];
  int                         pix_row, pix_col;
  longint                     partial[MAX_IMAGE_DIM];

  assign pending_o = pooled_expected.size();

  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] round_sat(longint x, int s);
    longint q;
    q = (x + (longint'(1) << (s - 1))) >>> s;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return SAMPLE_W'(q);
  endfunction

  task automatic feed_pixel(logic signed [SAMPLE_W-1:0] v);
    int w, h, k, p, r, c, cw, ch, rem_x, rem_y, ry, rx, pr, pc;
    longint acc;
    logic signed [SAMPLE_W-1:0] act;
    pooled_t res;
    w = clamp_dim(width_q, MAX_IMAGE_DIM);
    h = clamp_dim(height_q, MAX_IMAGE_DIM);
    k = clamp_dim(ksize_q, MAX_KERNEL);
    p = clamp_dim(psize_q, MAX_POOL);
    if (pix_row >= h || pix_col >= w) begin
      pix_row = 0;
      pix_col = 0;
    end
    rows_kept[pix_row % MAX_KERNEL][pix_col] = v;
    if (pix_row >= k - 1 && pix_col >= k - 1) begin
      r = pix_row - (k - 1);
      c = pix_col - (k - 1);
      cw = w - k + 1;
      ch = h - k + 1;
      rem_x = cw % p;
      rem_y = ch % p;
      if (r >= rem_y && c >= rem_x) begin
        ry = (r - rem_y) % p;
        rx = (c - rem_x) % p;
        pr = (r - rem_y) / p;
        pc = (c - rem_x) / p;
        acc = 0;
        for (int u = 0; u < k; u++)
          for (int t = 0; t < k; t++)
            acc += longint'(weights[u * k + t]) * longint'(rows_kept[(r + u) % MAX_KERNEL][c + t]);
        acc += longint'(bias_q) * 16384;
        if (relu_q && acc < 0) acc = 0;
        act = round_sat(acc, 14);
        if (ry == 0 && rx == 0) partial[pc] = act;
        else if (method_q == METHOD_MAX) begin
          if (longint'(act) > partial[pc]) partial[pc] = act;
        end else partial[pc] += act;
        if (ry == p - 1 && rx == p - 1) begin
          if (method_q == METHOD_MAX) res.value = SAMPLE_W'(partial[pc]);
          else res.value = round_sat(partial[pc] * AREA_RECIP[p], 16);
          res.row = POS_W'(pr);
          res.col = POS_W'(pc);
          res.last = (pr == ch / p - 1) && (pc == cw / p - 1);
          pooled_expected.insert(pooled_expected.size(), res);
        end
      end
    end
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
      if (pix_row >= h) pix_row = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t e;
    if (!rst_ni) begin
      pooled_expected.delete();
      width_q = 6'd32;
      height_q = 6'd32;
      ksize_q = 3'd7;
      psize_q = 3'd2;
      method_q = METHOD_MAX;
      bias_q = '0;
      relu_q = 1'b1;
      pix_row = 0;
      pix_col = 0;
      foreach (weights[i]) weights[i] = '0;
      foreach (rows_kept[i, j]) rows_kept[i][j] = '0;
      foreach (partial[i]) partial[i] = 0;
      errors_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_IMAGE_WIDTH: begin
            width_q = pwdata[5:0];
            pix_row = 0;
            pix_col = 0;
          end
          REG_IMAGE_HEIGHT: begin
            height_q = pwdata[5:0];
            pix_row = 0;
            pix_col = 0;
          end
          REG_KERNEL_SIZE: begin
            ksize_q = pwdata[2:0];
            pix_row = 0;
            pix_col = 0;
          end
          REG_POOL_SIZE: begin
            psize_q = pwdata[2:0];
            pix_row = 0;
            pix_col = 0;
          end
          REG_POOL_METHOD: method_q = pool_method_e'(pwdata[0]);
          REG_KERNEL_BIAS: bias_q = pwdata[15:0];
          REG_RELU_ENABLE: relu_q = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (pooled_expected.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d row %0d col %0d last %0b",
                   $time, pooled_value_o, pool_row_o, pool_col_o, last_o);
          errors_o++;
        end else begin
          e = pooled_expected.pop_front();
          if (pooled_value_o !== e.value) begin
            $display("%0t: pooled_value expected %0d actual %0d", $time, e.value,
                     pooled_value_o);
            errors_o++;
          end
          if (pool_row_o !== e.row) begin
            $display("%0t: pool_row expected %0d actual %0d", $time, e.row, pool_row_o);
            errors_o++;
          end
          if (pool_col_o !== e.col) begin
            $display("%0t: pool_col expected %0d actual %0d", $time, e.col, pool_col_o);
            errors_o++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, last_o);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (cmd_i == CMD_WEIGHT) begin
          if (weight_index_i < WEIGHT_COUNT) weights[weight_index_i] = value_i;
        end else feed_pixel(value_i);
      end
    end
  end

endmodule

// ----- tb/conv_relu_pool_layer_core_test.sv -----
`timescale 1ns / 1ps
// testbench top of the conv / relu / pool layer: stimulus, idling and verdict
// depends on crp_pkg, conv_relu_pool_layer_core and conv_relu_pool_layer_core_check
module conv_relu_pool_layer_core_test import crp_pkg::*;;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel, penable, pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [31:0]                pwdata, prdata;
  logic                       pready;
  logic                       in_valid_i, in_ready_o;
  logic                       cmd_i;
  logic [WIDX_W-1:0]          weight_index_i;
  logic signed [SAMPLE_W-1:0] value_i;
  logic                       out_valid_o, out_ready_i;
  logic signed [SAMPLE_W-1:0] pooled_value_o;
  logic [POS_W-1:0]           pool_row_o, pool_col_o;
  logic                       last_o;
  int                         errors, pending, sent;
  bit                         no_idle;

  always #1 clk_i = ~clk_i;

  conv_relu_pool_layer_core u_top (.*);

  conv_relu_pool_layer_core_check u_check (.*, .errors_o(errors), .pending_o(pending));

  always @(posedge clk_i) out_ready_i <= no_idle || ($urandom_range(99) >= 11);

  task automatic reg_write(reg_idx_e idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(cmd_e cmd, logic [WIDX_W-1:0] idx, logic signed [SAMPLE_W-1:0] v);
    if (!no_idle && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    weight_index_i <= idx;
    value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_weights(bit wide);
    for (int i = 0; i < WEIGHT_COUNT; i++)
      send(CMD_WEIGHT, WIDX_W'(i), wide ? SAMPLE_W'($urandom) :
           SAMPLE_W'($signed($urandom_range(0, 8000)) - 4000));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_pixel();
    if ($urandom_range(3) == 0) return SAMPLE_W'($urandom);
    return SAMPLE_W'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  task automatic run_image(int w, int h, int k, int p, int m, int b, int r, int npix,
                           bit edges);
    logic signed [SAMPLE_W-1:0] edge_vals [5] = '{16'sh7fff, -16'sh8000, 0, 1, -1};
    drain();
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_KERNEL_SIZE, k);
    reg_write(REG_POOL_SIZE, p);
    reg_write(REG_POOL_METHOD, m);
    reg_write(REG_KERNEL_BIAS, b);
    reg_write(REG_RELU_ENABLE, r);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(40) == 0)
        send(CMD_WEIGHT, WIDX_W'($urandom_range(63)), SAMPLE_W'($urandom));
      send(CMD_PIXEL, WIDX_W'($urandom), (edges && i < 5) ? edge_vals[i] : rand_pixel());
    end
    drain();
  endtask

  function automatic int pick_dim();
    int s;
    s = $urandom_range(99);
    if (s < 70) return $urandom_range(1, 8);
    if (s < 85) return $urandom_range(9, 32);
    if (s < 95) return 32;
    return (s < 97) ? 0 : $urandom_range(33, 63);
  endfunction

  function automatic int clamp_cfg(int v);
    if (v < 1) return 1;
    if (v > MAX_IMAGE_DIM) return MAX_IMAGE_DIM;
    return v;
  endfunction

  initial begin
    int w, h, n, raw_w, raw_h;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_WEIGHT;
    weight_index_i <= '0;
    value_i <= '0;
    no_idle = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_weights(1'b0);
    send(CMD_WEIGHT, WIDX_W'(0), 16'sh7fff);
    send(CMD_WEIGHT, WIDX_W'(1), -16'sh8000);
    send(CMD_WEIGHT, WIDX_W'(49), 16'sh1234);
    send(CMD_WEIGHT, WIDX_W'(63), -16'sh0001);
    drain();
    reg_write(reg_idx_e'(7), 32'hffff_ffff);
    run_image(3, 3, 1, 1, METHOD_MAX, 0, 1, 9, 1'b1);
    run_image(4, 3, 2, 2, METHOD_AVG, -32768, 0, 12, 1'b1);
    run_image(2, 2, 3, 1, METHOD_MAX, 32767, 1, 4, 1'b0);

    load_weights(1'b0);
    run_image(32, 3, 1, 4, METHOD_AVG, 32767, 0, 96, 1'b1);
    run_image(1, 32, 1, 1, METHOD_MAX, -32768, 1, 32, 1'b1);
    run_image(8, 8, 7, 2, METHOD_AVG, 100, 0, 64, 1'b0);
    no_idle = 1'b1;
    run_image(9, 9, 3, 3, METHOD_MAX, -200, 0, 100, 1'b0);
    no_idle = 1'b0;
    while (sent < 750) begin
      if ($urandom_range(4) == 0) load_weights($urandom_range(1));
      raw_w = pick_dim();
      raw_h = pick_dim();
      w = clamp_cfg(raw_w);
      h = clamp_cfg(raw_h);
      n = w * h + $urandom_range(0, w * h / 2);
      if (n > 200) n = 200;
      run_image(raw_w, raw_h, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(1),
                $signed($urandom_range(0, 65535)) - 32768, $urandom_range(1), n, 1'b0);
    end
    drain();
    if (errors == 0) $display("PASS conv_relu_pool_layer_core");
    else $display("FAIL conv_relu_pool_layer_core");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL conv_relu_pool_layer_core");
    $finish;
  end

endmodule
